FILE: src/lbrn_pkg.sv
// ----------------------------------------------------------------------------
// lbrn_pkg
// Shared widths, constants and types of the label renumbering block.
// ----------------------------------------------------------------------------
package lbrn_pkg;

	// Width of the label field on the input port.
	localparam int unsigned LABEL_IN_W = 16;
	// Number of label bits that index the remap table.
	localparam int unsigned LABEL_BITS = 16;
	// Width of a dense label number.
	localparam int unsigned NUM_W = 17;
	// Width of the frame epoch tag kept with every table entry.
	localparam int unsigned EPOCH_W = 8;

	localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};
	localparam logic [EPOCH_W-1:0] EPOCH_NONE = '0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

	// Configuration port.
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic REG_BG_RELABEL = 1'b0;

	// One remap table entry: the entry counts as seen only when its epoch
	// equals the epoch of the frame that reads it.
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [NUM_W-1:0]   number;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

FILE: src/lbrn_ram.sv
// ----------------------------------------------------------------------------
// lbrn_ram
// Simple dual-port synchronous RAM, one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module lbrn_ram #(
	parameter int unsigned ADDR_W = 16,
	parameter int unsigned DATA_W = 25
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	localparam int unsigned DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/lbrn_regs.sv
// ----------------------------------------------------------------------------
// lbrn_regs
// APB register bank holding the background labelling switch.
// ----------------------------------------------------------------------------
module lbrn_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lbrn_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [lbrn_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [lbrn_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                 pready,
	output logic                                 bg_relabel
);

	logic bg_q;
	logic sel_bg;

	// Register index is the word address; byte offsets within a word are ignored.
	assign sel_bg = (paddr[lbrn_pkg::CFG_ADDR_W-1] == lbrn_pkg::REG_BG_RELABEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && sel_bg) begin
			bg_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_bg) begin
			prdata[0] = bg_q;
		end
	end

	assign pready     = 1'b1;
	assign bg_relabel = bg_q;

endmodule

FILE: src/label_renumber_first_seen.sv
// ----------------------------------------------------------------------------
// label_renumber_first_seen
// Renumbers a raster stream of component labels densely by first appearance.
// ----------------------------------------------------------------------------
// A pixel transaction is taken on any clock edge where start is high and busy
// is low. It then passes the registered table read (stage 1) and the result
// registers, and its result (new_label, newly_assigned) is marked by
// result_valid for exactly one cycle as it leaves them; the receiver
// cannot stall it. In normal running the block takes one pixel per
// clock, set by the single read-modify-write of the remap table RAM, with the
// entry just written forwarded to the pixel behind it. Frames are not cleared
// entry by entry: each table entry carries an 8-bit frame epoch, and a frame
// start simply advances the epoch. After reset, and on every frame start that
// would wrap the epoch (once every 255 frames), the block raises busy for a
// clearing pass over all 2^LABEL_BITS table entries (65536), during which
// no pixel is taken; a frame start that triggers the pass is itself accepted
// and is processed right after the pass. Configuration writes are accepted at
// all times but must only be made while no pixel is in flight.
// ----------------------------------------------------------------------------
module label_renumber_first_seen (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Pixel command interface.
	input  logic                                 start,
	output logic                                 busy,
	input  logic [lbrn_pkg::LABEL_IN_W-1:0]      old_label,
	input  logic                                 frame_start,
	// Result interface.
	output logic                                 result_valid,
	output logic [lbrn_pkg::NUM_W-1:0]           new_label,
	output logic                                 newly_assigned,
	// Configuration interface.
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lbrn_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [lbrn_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [lbrn_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                 pready
);

	localparam int unsigned IDX_W = lbrn_pkg::LABEL_BITS;

	typedef enum logic [2:0] {
		ST_CLEAR   = 3'b001,
		ST_RELEASE = 3'b010,
		ST_RUN     = 3'b100
	} state_t;

	state_t state_q;

	logic bg_relabel;

	lbrn_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.bg_relabel (bg_relabel)
	);

	// Accept side.
	logic                             accept;
	logic [IDX_W-1:0]                 in_idx;
	logic                             wrap;
	logic [lbrn_pkg::EPOCH_W-1:0]     epoch_q;
	logic [lbrn_pkg::EPOCH_W-1:0]     in_epoch;

	// Pixel held across a clearing pass.
	logic                             hold_valid_q;
	logic [IDX_W-1:0]                 hold_idx_q;

	logic [IDX_W-1:0]                 clr_addr_q;

	// Stage 1: table data arrives.
	logic                             valid_s1;
	logic [IDX_W-1:0]                 idx_s1;
	logic                             frame_start_s1;
	logic [lbrn_pkg::EPOCH_W-1:0]     epoch_s1;

	// Forwarding of the entry written on the previous edge.
	logic                             fwd_valid_q;
	logic [IDX_W-1:0]                 fwd_addr_q;
	lbrn_pkg::entry_t                 fwd_data_q;

	logic [lbrn_pkg::NUM_W-1:0]       next_number_q;

	// RAM ports.
	logic                             ram_we;
	logic [IDX_W-1:0]                 ram_waddr;
	lbrn_pkg::entry_t                 ram_wdata;
	logic                             ram_re;
	logic [IDX_W-1:0]                 ram_raddr;
	logic [lbrn_pkg::ENTRY_W-1:0]     ram_rdata;

	// Stage 1 computation.
	lbrn_pkg::entry_t                 cur_entry;
	logic                             seen;
	logic                             active;
	logic [lbrn_pkg::NUM_W-1:0]       base_number;
	logic [lbrn_pkg::NUM_W-1:0]       bumped_number;
	logic                             assign_new;
	logic [lbrn_pkg::NUM_W-1:0]       result_number;

	assign busy   = (state_q != ST_RUN);
	assign accept = start && !busy;
	assign in_idx = IDX_W'(old_label);

	// A frame start moves to the next epoch; from the last epoch the table must
	// be swept clean first and the frame restarts at the first epoch.
	assign wrap     = frame_start && (epoch_q == lbrn_pkg::EPOCH_MAX);
	assign in_epoch = frame_start ? (wrap ? lbrn_pkg::EPOCH_FIRST : epoch_q + 1'b1) : epoch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			hold_valid_q <= 1'b0;
			epoch_q      <= lbrn_pkg::EPOCH_FIRST;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == {IDX_W{1'b1}}) begin
						state_q <= ST_RELEASE;
					end
				end
				ST_RELEASE: begin
					hold_valid_q <= 1'b0;
					state_q      <= ST_RUN;
				end
				ST_RUN: begin
					if (accept) begin
						epoch_q <= in_epoch;
						if (wrap) begin
							hold_valid_q <= 1'b1;
							clr_addr_q   <= '0;
							state_q      <= ST_CLEAR;
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wrap) begin
			hold_idx_q <= in_idx;
		end
	end

	// Issue of the table read.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = in_idx;
		if (state_q == ST_RELEASE) begin
			ram_re    = hold_valid_q;
			ram_raddr = hold_idx_q;
		end else if (accept && !wrap) begin
			ram_re = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			idx_s1 <= ram_raddr;
			if (state_q == ST_RELEASE) begin
				frame_start_s1 <= 1'b1;
				epoch_s1       <= lbrn_pkg::EPOCH_FIRST;
			end else begin
				frame_start_s1 <= frame_start;
				epoch_s1       <= in_epoch;
			end
		end
	end

	// Stage 1: resolve the entry, assign a number if the label is new and active.
	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == idx_s1)) begin
			cur_entry = fwd_data_q;
		end else begin
			cur_entry = lbrn_pkg::entry_t'(ram_rdata);
		end
		seen          = (cur_entry.epoch == epoch_s1);
		active        = bg_relabel || (idx_s1 != '0);
		base_number   = frame_start_s1 ? '0 : next_number_q;
		bumped_number = (base_number < lbrn_pkg::NUM_MAX) ? base_number + 1'b1 : base_number;
		assign_new    = valid_s1 && active && !seen;
		if (!active) begin
			result_number = '0;
		end else if (!seen) begin
			result_number = bumped_number;
		end else begin
			result_number = cur_entry.number;
		end
	end

	// Table write port: clearing sweep or the new entry of stage 1.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we           = 1'b1;
			ram_waddr        = clr_addr_q;
			ram_wdata.epoch  = lbrn_pkg::EPOCH_NONE;
			ram_wdata.number = '0;
		end else begin
			ram_we           = assign_new;
			ram_waddr        = idx_s1;
			ram_wdata.epoch  = epoch_s1;
			ram_wdata.number = bumped_number;
		end
	end

	lbrn_ram #(
		.ADDR_W (IDX_W),
		.DATA_W (lbrn_pkg::ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q   <= 1'b0;
			next_number_q <= '0;
			result_valid  <= 1'b0;
		end else begin
			fwd_valid_q  <= assign_new;
			result_valid <= valid_s1;
			if (valid_s1) begin
				next_number_q <= assign_new ? bumped_number : base_number;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (assign_new) begin
			fwd_addr_q        <= idx_s1;
			fwd_data_q.epoch  <= epoch_s1;
			fwd_data_q.number <= bumped_number;
		end
		if (valid_s1) begin
			new_label      <= result_number;
			newly_assigned <= assign_new;
		end
	end

endmodule

FILE: test/label_renumber_first_seen_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_renumber_first_seen_tb
// Self-checking testbench for the first-seen label renumbering block.
// ----------------------------------------------------------------------------
// Pixels are pushed through the start/busy command port while a predictor
// written in this file renumbers the same stream. Every result transaction is
// compared field by field with the oldest prediction. The run covers directed
// corner cases, a long stream of short random frames with register changes
// between phases, and one longer frame of distinct labels in scrambled order.
// ----------------------------------------------------------------------------
module label_renumber_first_seen_tb;

	import lbrn_pkg::*;

	// Clock period in ns and the hard limit on the length of the run. The
	// limit allows for the clearing pass after reset, the passes that every
	// epoch wrap causes and sender gaps, several times over.
	localparam int unsigned CLK_PERIOD = 12;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	// Cycles to let pass after the last result before touching the register.
	localparam int unsigned SETTLE_CYCLES = 4;
	// Pixels per phase of the random stream.
	localparam int unsigned PHASE_PIXELS = 190;
	localparam int unsigned PHASES = 7;
	// Distinct labels in the scrambled frame.
	localparam int unsigned DISTINCT_LABELS = 64;
	localparam int unsigned TABLE_SIZE = 1 << LABEL_BITS;

	// Byte address of the background register on the configuration port.
	localparam logic [CFG_ADDR_W-1:0] BG_ADDR = CFG_ADDR_W'(4 * REG_BG_RELABEL);

	// One predicted result transaction.
	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic             fresh;
	} dense_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [LABEL_IN_W-1:0] old_label;
	logic                  frame_start;
	logic                  result_valid;
	logic [NUM_W-1:0]      new_label;
	logic                  newly_assigned;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	label_renumber_first_seen u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.old_label      (old_label),
		.frame_start    (frame_start),
		.result_valid   (result_valid),
		.new_label      (new_label),
		.newly_assigned (newly_assigned),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// ------------------------------------------------------------------------
	// Predictor state: its own copy of the remap map, the seen flags, the
	// running counter and the background register. Instead of wiping all
	// seen flags on every frame start, the labels touched in the current
	// frame are remembered and only those are cleared.
	// ------------------------------------------------------------------------
	logic [NUM_W-1:0]    remap_map [TABLE_SIZE];
	bit                  seen_map [TABLE_SIZE];
	int unsigned         touched_labels [$];
	logic [NUM_W-1:0]    label_counter;
	bit                  background_on;

	// Predicted results waiting for their transaction, oldest first.
	dense_t              dense_label_q [$];

	int unsigned         mismatch_count;
	int unsigned         pixels_checked;
	int unsigned         frames_started;
	int unsigned         reg_writes;
	longint unsigned     cycle_count;
	bit                  gaps_on;
	dense_t              oldest_label;

	// Clock: free running from time zero.
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop. A correct block never comes near this limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run limit of %0d cycles reached, %0d results outstanding",
				$time, CYCLE_LIMIT, dense_label_q.size());
			$display("label_renumber_first_seen_tb: errors");
			$finish;
		end
	end

	// Renumbers one accepted pixel exactly as the block must and returns the
	// result that it should produce. A frame start empties the map before the
	// pixel itself is looked up.
	task automatic assign_dense_label(input logic [LABEL_IN_W-1:0] label,
			input logic first_pixel, output dense_t res);
		int unsigned idx;
		idx = int'(label[LABEL_BITS-1:0]);
		res = '0;
		if (first_pixel) begin
			foreach (touched_labels[k])
				seen_map[touched_labels[k]] = 1'b0;
			touched_labels.delete();
			label_counter = '0;
		end
		// Background zero bypasses the map entirely unless it is labelled.
		if (background_on || idx != 0) begin
			if (!seen_map[idx]) begin
				if (label_counter != NUM_MAX)
					label_counter = label_counter + 1'b1;
				remap_map[idx] = label_counter;
				seen_map[idx] = 1'b1;
				touched_labels.push_back(idx);
				res.fresh = 1'b1;
			end
			res.number = remap_map[idx];
		end
	endtask

	// Result checker. The receiver cannot stall, so every strobe is a result
	// transaction and is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (dense_label_q.size() == 0) begin
				$display("%0t: result with nothing expected: new_label %0d newly_assigned %0b",
					$time, new_label, newly_assigned);
				mismatch_count++;
			end else begin
				oldest_label = dense_label_q.pop_front();
				pixels_checked++;
				if (new_label !== oldest_label.number) begin
					$display("%0t: new_label expected %0d actual %0d",
						$time, oldest_label.number, new_label);
					mismatch_count++;
				end
				if (newly_assigned !== oldest_label.fresh) begin
					$display("%0t: newly_assigned expected %0b actual %0b",
						$time, oldest_label.fresh, newly_assigned);
					mismatch_count++;
				end
			end
		end
	end

	// Sends one pixel transaction. When gaps are on it may first idle with noise
	// on the fields, then holds start until busy is seen low at an edge.
	// On return start is still high, so a following pixel goes back to back.
	task automatic send_pixel(input logic [LABEL_IN_W-1:0] label, input logic first_pixel);
		dense_t res;
		if (gaps_on && $urandom_range(0, 99) < 8) begin
			start <= 1'b0;
			old_label <= LABEL_IN_W'($urandom);
			frame_start <= 1'($urandom);
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		old_label <= label;
		frame_start <= first_pixel;
		do @(posedge clk); while (busy);
		assign_dense_label(label, first_pixel, res);
		dense_label_q.push_back(res);
		if (first_pixel)
			frames_started++;
	endtask

	// Stops the pixel stream and waits until every prediction has been met,
	// then lets the settle time pass so that nothing is left in the pipeline.
	task automatic drain_pixels();
		start <= 1'b0;
		@(posedge clk);
		while (dense_label_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register access: a setup phase, then an access phase. The transfer
	// completes at the edge where psel, penable and pready are all high. The
	// bus then idles before the task returns.
	task automatic cfg_access(input logic is_write, input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] wdata, output logic [CFG_DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Reads the background register back and compares it with the model.
	task automatic check_background_reg();
		logic [CFG_DATA_W-1:0] rd;
		cfg_access(1'b0, BG_ADDR, '0, rd);
		if (rd !== CFG_DATA_W'(background_on)) begin
			$display("%0t: bg_relabel readback expected %0d actual %0d",
				$time, background_on, rd);
			mismatch_count++;
		end
	endtask

	task automatic set_background(input bit value);
		logic [CFG_DATA_W-1:0] rd;
		cfg_access(1'b1, BG_ADDR, CFG_DATA_W'(value), rd);
		background_on = value;
		reg_writes++;
		check_background_reg();
	endtask

	// ------------------------------------------------------------------------
	// Directed tests.
	// ------------------------------------------------------------------------

	// Straight after reset, without any frame start, the map accumulates.
	// Background is off, so zero passes through and never takes a number.
	task automatic test_accumulate_from_reset();
		check_background_reg();
		set_background(1'b0);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h0001, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h8000, 1'b0);
		send_pixel(16'h0000, 1'b0);
		drain_pixels();
	endtask

	// Background turned on in the middle of a frame: zero now takes the next
	// number, and numbers handed out earlier stay as they were.
	task automatic test_background_midframe();
		set_background(1'b1);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'h0001, 1'b0);
		send_pixel(16'h7FFF, 1'b0);
		drain_pixels();
	endtask

	// Frame starts restart the numbering, also on back-to-back pixels. With
	// background off again, a zero that already has a number still reads zero.
	task automatic test_frame_restart();
		send_pixel(16'h0001, 1'b1);
		send_pixel(16'h0001, 1'b1);
		send_pixel(16'h0000, 1'b0);
		drain_pixels();
		set_background(1'b0);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'h5555, 1'b0);
		send_pixel(16'h0000, 1'b1);
		send_pixel(16'hAAAA, 1'b0);
		drain_pixels();
	endtask

	// ------------------------------------------------------------------------
	// Random frames. Frames are short so that many frame starts happen (more
	// than the block's epoch range), and each frame draws most pixels from a
	// small pool of labels so that repeats dominate, as in a real image.
	// Between phases the register may change, sometimes mid-frame.
	// ------------------------------------------------------------------------
	task automatic test_random_frames();
		logic [LABEL_IN_W-1:0] pool [8];
		int unsigned pool_n;
		int unsigned frame_left;
		int unsigned sent;
		logic [LABEL_IN_W-1:0] label;
		logic first_pixel;
		pool_n = 1;
		pool[0] = '0;
		frame_left = 0;
		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			drain_pixels();
			if (ph < 2)
				set_background(ph[0]);
			else
				set_background(1'($urandom));
			// One phase runs with no sender gaps at all.
			gaps_on = (ph != 3);
			if ($urandom_range(0, 2) != 0)
				frame_left = 0;
			sent = 0;
			while (sent < PHASE_PIXELS) begin
				first_pixel = 1'b0;
				if (frame_left == 0) begin
					first_pixel = 1'b1;
					if ($urandom_range(0, 15) == 0)
						frame_left = $urandom_range(8, 30);
					else
						frame_left = $urandom_range(1, 4);
					pool_n = $urandom_range(1, 8);
					for (int unsigned k = 0; k < pool_n; k++) begin
						case ($urandom_range(0, 9))
							0: pool[k] = '0;
							1: pool[k] = '1;
							default: pool[k] = LABEL_IN_W'($urandom);
						endcase
					end
				end
				if ($urandom_range(0, 99) < 85)
					label = pool[$urandom_range(0, pool_n - 1)];
				else
					label = LABEL_IN_W'($urandom);
				send_pixel(label, first_pixel);
				frame_left--;
				sent++;
			end
		end
		gaps_on = 1'b1;
		drain_pixels();
	endtask

	// ------------------------------------------------------------------------
	// One frame with background on that visits a run of distinct labels once,
	// in a scrambled order, with no sender gaps, so every pixel takes the next
	// number. Eight random labels follow, then a short frame checks that
	// everything was cleared.
	// ------------------------------------------------------------------------
	task automatic test_many_labels();
		int unsigned offset;
		int unsigned stride;
		offset = $urandom;
		// Any odd stride gives distinct labels.
		stride = ($urandom_range(1, 30000) * 2) + 1;
		set_background(1'b1);
		gaps_on = 1'b0;
		for (int unsigned i = 0; i < DISTINCT_LABELS; i++)
			send_pixel(LABEL_IN_W'(i * stride + offset), i == 0);
		for (int unsigned i = 0; i < 8; i++)
			send_pixel(LABEL_IN_W'($urandom), 1'b0);
		gaps_on = 1'b1;
		drain_pixels();
		set_background(1'b0);
		send_pixel(LABEL_IN_W'(offset), 1'b1);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(LABEL_IN_W'(offset), 1'b0);
		drain_pixels();
	endtask

	// ------------------------------------------------------------------------
	// Main sequence: reset once, run the tests in turn, then report.
	// ------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		old_label = '0;
		frame_start = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycle_count = 0;
		mismatch_count = 0;
		pixels_checked = 0;
		frames_started = 0;
		reg_writes = 0;
		gaps_on = 1'b1;
		label_counter = '0;
		background_on = 1'b0;
		foreach (seen_map[k])
			seen_map[k] = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The block clears its table after reset; the first pixel simply
		// waits on busy until that pass is over.
		test_accumulate_from_reset();
		test_background_midframe();
		test_frame_restart();
		test_random_frames();
		test_many_labels();

		$display("Checked %0d pixel results over %0d frames, %0d register writes.",
			pixels_checked, frames_started, reg_writes);
		$display("Covered pass-through and labelled background, mid-frame register");
		$display("changes, epoch wrap and a long frame of distinct labels.");
		if (mismatch_count == 0 && dense_label_q.size() == 0) begin
			$display("label_renumber_first_seen_tb: clean");
		end else begin
			$display("label_renumber_first_seen_tb: errors");
		end
		$finish;
	end

endmodule
